[hdl/kem_pkg.sv]
// ----------------------------------------------------------------------------
// kem_pkg: shared types and constants for the Kirsch edge magnitude block
// Field widths, register indexes, image bounds and the divide-by-15 constant.
// ----------------------------------------------------------------------------
`default_nettype none

package kem_pkg;

  localparam int PIX_W      = 8;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int LINE_W     = 2 * PIX_W;

  localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(MAX_HEIGHT);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

  // compass response |5*pos - 3*neg| fits 0..3825
  localparam int RESP_W    = 12;
  localparam int SUM_W     = 11;
  localparam int SCALED_W  = 13;
  // floor(x / 15) = (x * 4370) >> 16 for x <= 3825
  localparam int DIV_K_W   = 13;
  localparam logic [DIV_K_W-1:0] DIV15_RECIP = DIV_K_W'(4370);
  localparam int DIV15_SHIFT = 16;
  localparam int PROD_W    = RESP_W + DIV_K_W;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
  // up to four requests in flight ahead of the queue
  localparam int FIFO_ADMIT = FIFO_DEPTH - 4;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic emit;
    logic last;
  } tag_t;

  typedef logic [2:0][2:0][PIX_W-1:0] window_t;
  typedef logic [7:0][PIX_W-1:0]      ring_t;
  typedef logic [7:0][RESP_W-1:0]     resp_t;

endpackage

`default_nettype wire

[hdl/kem_line_ram.sv]
// ----------------------------------------------------------------------------
// kem_line_ram: two-row line store
// One entry per column holds the pixels of the two rows above; registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kem_line_ram import kem_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [COL_W-1:0]  rd_addr,
  output logic      [LINE_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [COL_W-1:0]  wr_addr,
  input  wire logic [LINE_W-1:0] wr_data
);

  logic [LINE_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/kem_compass.sv]
// ----------------------------------------------------------------------------
// kem_compass: eight Kirsch compass responses, maximum and divide by 15
// Two register stages; the quotient goes straight into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module kem_compass import kem_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire tag_t             in_tag,
  input  wire window_t          win,
  output logic                  push,
  output logic      [PIX_W-1:0] push_strength,
  output logic                  push_last
);

  ring_t               ring;
  logic [SUM_W-1:0]    total;
  logic [SCALED_W-1:0] total3;
  resp_t               resp;

  resp_t               resp_q;
  logic                a_valid;
  tag_t                a_tag;

  logic [RESP_W-1:0]   m0, m1, m2, m3, m4, m5, best;
  logic [RESP_W-1:0]   best_q;
  logic                b_valid;
  tag_t                b_tag;
  logic [PROD_W-1:0]   prod;

  function automatic logic [RESP_W-1:0] max2(input logic [RESP_W-1:0] a,
                                              input logic [RESP_W-1:0] b);
    max2 = (a > b) ? a : b;
  endfunction

  // ring counter-clockwise from the east neighbour
  always_comb begin
    ring[0] = win[1][2];
    ring[1] = win[0][2];
    ring[2] = win[0][1];
    ring[3] = win[0][0];
    ring[4] = win[1][0];
    ring[5] = win[2][0];
    ring[6] = win[2][1];
    ring[7] = win[2][2];
  end

  // 5*pos - 3*(total - pos) = 8*pos - 3*total
  always_comb begin
    logic [SUM_W-1:0]    pos;
    logic [SCALED_W-1:0] pos8;
    logic [SCALED_W-1:0] diff;
    total = '0;
    for (int i = 0; i < 8; i++) begin
      total = total + SUM_W'(ring[i]);
    end
    total3 = {total, 1'b0} + SCALED_W'(total);
    for (int k = 0; k < 8; k++) begin
      pos  = SUM_W'(ring[3'(k)]) + SUM_W'(ring[3'(k + 1)]) + SUM_W'(ring[3'(k + 7)]);
      pos8 = {pos[SUM_W-2:0], 3'b000};
      diff = (pos8 >= total3) ? (pos8 - total3) : (total3 - pos8);
      resp[k] = diff[RESP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    resp_q <= resp;
    a_tag  <= in_tag;
  end

  always_comb begin
    m0   = max2(resp_q[0], resp_q[1]);
    m1   = max2(resp_q[2], resp_q[3]);
    m2   = max2(resp_q[4], resp_q[5]);
    m3   = max2(resp_q[6], resp_q[7]);
    m4   = max2(m0, m1);
    m5   = max2(m2, m3);
    best = max2(m4, m5);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    best_q <= best;
    b_tag  <= a_tag;
  end

  assign prod          = PROD_W'(best_q) * PROD_W'(DIV15_RECIP);
  assign push_strength = prod[DIV15_SHIFT +: PIX_W];
  assign push_last     = b_tag.last;
  assign push          = b_valid & b_tag.emit;

endmodule

`default_nettype wire

[hdl/kem_out_fifo.sv]
// ----------------------------------------------------------------------------
// kem_out_fifo: result queue toward the output stream
// Absorbs requests still in flight when the downstream side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module kem_out_fifo import kem_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [PIX_W-1:0] push_strength,
  input  wire logic             push_last,
  output logic                  admit,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [PIX_W-1:0] m_axis_tdata,   // [7:0] edge_strength
  output logic                  m_axis_tlast
);

  logic [PIX_W:0]          mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_CNT_W-1:0]   count;
  logic                    pop;

  assign m_axis_tvalid = (count != '0);
  assign pop           = m_axis_tvalid & m_axis_tready;
  assign admit         = (count < FIFO_CNT_W'(FIFO_ADMIT));
  assign m_axis_tdata  = mem[rd_ptr][PIX_W-1:0];
  assign m_axis_tlast  = mem[rd_ptr][PIX_W];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= {push_last, push_strength};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("result queue underflow");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == FIFO_CNT_W'($past(count) + FIFO_CNT_W'($past(push))
                                          - FIFO_CNT_W'($past(pop)))))
    else $error("result queue count mismatch");

endmodule

`default_nettype wire

[hdl/kirsch_edge_magnitude.sv]
// ----------------------------------------------------------------------------
// kirsch_edge_magnitude: streaming 3x3 Kirsch compass edge magnitude
// Raster pixels in, max compass response / 15 out for interior pixels only.
// ----------------------------------------------------------------------------
// A result passes the input stage, window, compass stages and result queue in order.
// Throughput: one pixel per cycle; line store read and write-back each once a cycle.
// Input stalls only when 4 or more results wait in the output queue.
// Reset: counters, pipeline and queue cleared, width 640, height 480.
// Line store is not cleared; its first two rows are filled by the first image.
`default_nettype none

module kirsch_edge_magnitude import kem_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [PIX_W-1:0]       s_axis_tdata,   // [7:0] pixel
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [PIX_W-1:0]       m_axis_tdata,   // [7:0] edge_strength
  output logic                        m_axis_tlast,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [WIDTH_W-1:0]  w_last;
  logic [HEIGHT_W-1:0] h_last;

  logic [COL_W-1:0]    column_count;
  logic [ROW_W-1:0]    row_count;
  logic [COL_W-1:0]    c_eff;
  logic [ROW_W-1:0]    r_eff;
  logic                col_end;
  logic                row_end;
  logic                accept;

  logic                s1_valid;
  logic [PIX_W-1:0]    s1_px;
  logic [COL_W-1:0]    s1_addr;
  tag_t                s1_tag;
  logic                fwd_hit;
  logic [LINE_W-1:0]   fwd_data;

  logic [LINE_W-1:0]   rd_data;
  logic [LINE_W-1:0]   line;
  logic [LINE_W-1:0]   wr_data;

  window_t             win;
  logic                w_valid;
  tag_t                w_tag;

  logic                push;
  logic [PIX_W-1:0]    push_strength;
  logic                push_last;
  logic                admit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width < WIDTH_MIN) begin
      w_eff = WIDTH_MIN;
    end else if (image_width > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end else begin
      w_eff = image_width;
    end
    if (image_height < HEIGHT_MIN) begin
      h_eff = HEIGHT_MIN;
    end else if (image_height > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end else begin
      h_eff = image_height;
    end
    w_last  = w_eff - 1'b1;
    h_last  = h_eff - 1'b1;
    c_eff   = (WIDTH_W'(column_count) > w_last) ? w_last[COL_W-1:0] : column_count;
    r_eff   = (HEIGHT_W'(row_count) > h_last) ? h_last[ROW_W-1:0] : row_count;
    col_end = (WIDTH_W'(c_eff) == w_last);
    row_end = (HEIGHT_W'(r_eff) == h_last);
  end

  assign s_axis_tready = admit;
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_end) begin
        column_count <= '0;
        row_count    <= row_end ? '0 : r_eff + 1'b1;
      end else begin
        column_count <= c_eff + 1'b1;
        row_count    <= r_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      w_valid  <= 1'b0;
    end else begin
      s1_valid <= accept;
      w_valid  <= s1_valid;
    end
  end

  // same column written back this cycle: take the write data instead
  always_ff @(posedge clk) begin
    s1_px       <= s_axis_tdata;
    s1_addr     <= c_eff;
    s1_tag.emit <= (r_eff >= ROW_W'(2)) && (c_eff >= COL_W'(2));
    s1_tag.last <= col_end & row_end;
    fwd_hit     <= s1_valid && (s1_addr == c_eff);
    fwd_data    <= wr_data;
  end

  kem_line_ram u_line_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (c_eff),
    .rd_data (rd_data),
    .wr_en   (s1_valid),
    .wr_addr (s1_addr),
    .wr_data (wr_data)
  );

  // low byte: row r-2, high byte: row r-1
  assign line    = fwd_hit ? fwd_data : rd_data;
  assign wr_data = {s1_px, line[LINE_W-1:PIX_W]};

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= line[PIX_W-1:0];
      win[1][2] <= line[LINE_W-1:PIX_W];
      win[2][2] <= s1_px;
    end
    w_tag <= s1_tag;
  end

  kem_compass u_compass (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (w_valid),
    .in_tag        (w_tag),
    .win           (win),
    .push          (push),
    .push_strength (push_strength),
    .push_last     (push_last)
  );

  kem_out_fifo u_out_fifo (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .push_strength (push_strength),
    .push_last     (push_last),
    .admit         (admit),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

[verif/tb_kirsch_edge_magnitude.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kirsch_edge_magnitude: self-checking bench for the Kirsch edge magnitude
// Streams raster images of many sizes through the block, models the line
// buffers, window and compass masks cycle-free, and compares every edge
// result and frame end flag in order. Both stream sides idle at random outside steady runs.
// ----------------------------------------------------------------------------
module tb_kirsch_edge_magnitude;
  import kem_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 260;
  localparam int MAX_REPORTS  = 40;
  localparam int PRIME_WIDTH  = 64;
  localparam int WIDE_ITEMS   = 60;
  localparam int TALL_ROWS    = 60;

  typedef struct packed {
    logic [PIX_W-1:0] strength;
    logic             last;
  } edge_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PIX_W-1:0]       s_axis_tdata = '0;   // [7:0] pixel
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [PIX_W-1:0]       m_axis_tdata;        // [7:0] edge_strength
  logic                   m_axis_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  kirsch_edge_magnitude dut (.*);

  always #5 clk = ~clk;

  // ---- edge predictor state
  logic [PIX_W-1:0]    line_mem [2][MAX_WIDTH];
  logic [PIX_W-1:0]    win [3][3];
  int unsigned         col_cnt = 0;
  int unsigned         row_cnt = 0;
  logic [WIDTH_W-1:0]  width_reg = WIDTH_RESET;
  logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;

  logic [PIX_W-1:0] pending_pixels [$];
  edge_result_t     expected_edges [$];

  bit          steady = 1'b0;
  int          errors = 0;
  int unsigned pixels_in = 0;
  int unsigned edges_out = 0;
  int unsigned frames_out = 0;
  int unsigned reg_writes = 0;
  int unsigned random_pixels = 0;
  int unsigned stall_cycles = 0;

  function automatic int unsigned eff_width();
    if (width_reg < WIDTH_MIN) return WIDTH_MIN;
    if (width_reg > WIDTH_MAX) return WIDTH_MAX;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < HEIGHT_MIN) return HEIGHT_MIN;
    if (height_reg > HEIGHT_MAX) return HEIGHT_MAX;
    return height_reg;
  endfunction

  // ring order: E, NE, N, NW, W, SW, S, SE; each mask is three adjacent at +5
  function automatic int compass_max();
    int ring [8];
    int total;
    int pos;
    int resp;
    int best;
    ring = '{win[1][2], win[0][2], win[0][1], win[0][0],
             win[1][0], win[2][0], win[2][1], win[2][2]};
    total = 0;
    best = 0;
    for (int i = 0; i < 8; i++) total += ring[i];
    for (int k = 0; k < 8; k++) begin
      pos = ring[k] + ring[(k + 1) % 8] + ring[(k + 7) % 8];
      resp = 5 * pos - 3 * (total - pos);
      if (resp < 0) resp = -resp;
      if (resp > best) best = resp;
    end
    return best;
  endfunction

  task automatic kirsch_step(input logic [PIX_W-1:0] px);
    int unsigned  w;
    int unsigned  h;
    int unsigned  c;
    int unsigned  r;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    edge_result_t res;
    w = eff_width();
    h = eff_height();
    c = (col_cnt >= w) ? w - 1 : col_cnt;
    r = (row_cnt >= h) ? h - 1 : row_cnt;
    top = line_mem[0][c];
    mid = line_mem[1][c];
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = px;
    line_mem[0][c] = mid;
    line_mem[1][c] = px;
    if (r >= 2 && c >= 2) begin
      res.strength = PIX_W'(compass_max() / 15);
      res.last = (r == h - 1) && (c == w - 1);
      expected_edges.push_back(res);
    end
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // ---- pixel driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        kirsch_step(s_axis_tdata);
        pixels_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_pixels.size() > 0 && (steady || $urandom_range(0, 99) >= 10)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_pixels.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- result monitor
  always @(posedge clk) begin
    edge_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        edges_out++;
        if (m_axis_tlast) frames_out++;
        if (expected_edges.size() == 0) begin
          report_mismatch($sformatf("unexpected result strength=%0d last=%0b",
                                    m_axis_tdata, m_axis_tlast));
        end else begin
          want = expected_edges.pop_front();
          if (m_axis_tdata !== want.strength)
            report_mismatch($sformatf("result %0d: strength %0d, expected %0d",
                                      edges_out, m_axis_tdata, want.strength));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("result %0d: last %0b, expected %0b",
                                      edges_out, m_axis_tlast, want.last));
        end
      end
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 10);
    end
  end

  // ---- watchdog: only counts while work is outstanding
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready) ||
          !(pending_pixels.size() > 0 || s_axis_tvalid || expected_edges.size() > 0 ||
            cfg_valid))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, expected_edges.size());
        $display("FAIL kirsch_edge_magnitude");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = val[WIDTH_W-1:0];
    else height_reg = val[HEIGHT_W-1:0];
    reg_writes++;
  endtask

  task automatic wait_idle();
    while (pending_pixels.size() > 0 || s_axis_tvalid || expected_edges.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // width data above bit 10 is don't-care; toggle it anyway
  task automatic configure(input logic [WIDTH_W-1:0] w, input logic [HEIGHT_W-1:0] h,
                           input logic [CFG_DATA_W-WIDTH_W-1:0] pad);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, {pad, w});
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  task automatic queue_pixels(input int unsigned count);
    repeat (count) begin
      case ($urandom_range(0, 5))
        0: pending_pixels.push_back(8'h00);
        1: pending_pixels.push_back(8'hFF);
        2: pending_pixels.push_back(PIX_W'($urandom_range(0, 15)));
        default: pending_pixels.push_back(PIX_W'($urandom));
      endcase
    end
  endtask

  initial begin
    logic [PIX_W-1:0]    directed_px [27];
    logic [WIDTH_W-1:0]  w;
    logic [HEIGHT_W-1:0] h;
    int unsigned         wc;
    int unsigned         hc;
    int unsigned         c;
    int unsigned         r;
    int unsigned         n;
    bit                  odd;

    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // smallest image: strongest edge, flat bright field, cross pattern
    directed_px = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
    configure(WIDTH_W'(3), HEIGHT_W'(3), '0);
    foreach (directed_px[i]) pending_pixels.push_back(directed_px[i]);

    // one full image fills every column that the later runs reach
    configure(WIDTH_W'(PRIME_WIDTH), HEIGHT_W'(3), '0);
    queue_pixels(3 * PRIME_WIDTH);

    // width beyond range clamps to the maximum, height zero clamps to 3
    configure('1, '0, '0);
    steady = 1'b1;
    queue_pixels(WIDE_ITEMS);

    // tallest image at the narrowest width, cut short
    configure('0, HEIGHT_W'(MAX_HEIGHT), '1);
    queue_pixels(3 * TALL_ROWS);
    wait_idle();
    steady = 1'b0;

    // small images, now and then cut short and resized mid-image
    while (random_pixels < RANDOM_ITEMS) begin
      odd = ($urandom_range(0, 7) == 0);
      if (odd) begin
        case ($urandom_range(0, 2))
          0: w = WIDTH_W'(MAX_WIDTH);
          1: w = '1;
          default: w = WIDTH_W'($urandom_range(0, 16));
        endcase
        case ($urandom_range(0, 2))
          0: h = HEIGHT_W'(MAX_HEIGHT);
          1: h = '1;
          default: h = HEIGHT_W'($urandom_range(0, 8));
        endcase
      end else begin
        w = WIDTH_W'($urandom_range(0, 16));
        h = HEIGHT_W'($urandom_range(0, 8));
      end
      configure(w, h, (CFG_DATA_W-WIDTH_W)'($urandom_range(0, 3)));
      wc = eff_width();
      hc = eff_height();
      c = (col_cnt >= wc) ? wc - 1 : col_cnt;
      r = (row_cnt >= hc) ? hc - 1 : row_cnt;
      if (odd || $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 60);
        // wide runs stay inside the filled columns
        if (wc > PRIME_WIDTH && n > PRIME_WIDTH - 1 - c) n = PRIME_WIDTH - 1 - c;
      end else begin
        n = (hc - 1 - r) * wc + (wc - c) + $urandom_range(0, 2) * wc * hc;
      end
      queue_pixels(n);
      random_pixels += n;
    end

    wait_idle();
    if (expected_edges.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_edges.size()));
    $display("covered %0d pixels (%0d in random phases), %0d edge results, %0d frame ends",
             pixels_in, random_pixels, edges_out, frames_out);
    $display("%0d register writes: widths 3 to 1024, heights 3 to 4096, clamped values, %s",
             reg_writes, "mid-image resizes");
    if (errors == 0) begin
      $display("PASS kirsch_edge_magnitude");
    end else begin
      $display("FAIL kirsch_edge_magnitude");
    end
    $finish;
  end

endmodule
